[design/mdag_pkg.sv]
// ----------------------------------------------------------------------------
// mdag_pkg: shared types and constants of the array address generator
// Item and result beat types, kind and status codes, table geometry,
// controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package mdag_pkg;

    // Table geometry
    localparam int MAX_ARRAYS = 64;
    localparam int MAX_DIMS   = 16;
    localparam int ARR_W      = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
    localparam int POS_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DIM_W      = $clog2(MAX_DIMS + 1);
    localparam int BND_DEPTH  = MAX_ARRAYS * MAX_DIMS;
    localparam int BND_AW     = (BND_DEPTH > 1) ? $clog2(BND_DEPTH) : 1;

    // Item kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BOUNDS = 2'd1;
    localparam logic [1:0] KIND_INDEX  = 2'd2;

    // Result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_UNDEF = 1'b1;

    // Input beat
    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         array_id;
        logic signed [31:0] base_address;
        logic [30:0]        element_size;
        logic [4:0]         dim_count;
        logic [4:0]         dim_number;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
        logic signed [31:0] index_value;
    } in_item_t;

    // Result beat
    typedef struct packed {
        logic [5:0]         result_array;
        logic signed [31:0] address;
        logic               status;
    } out_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic q_clear;
        logic hdr_write;
        logic bnd_write;
        logic walk_start;
        logic clr_write;
        logic stride_write;
        logic walk_mul_low;
        logic walk_mul_ext;
        logic walk_next;
        logic off_write;
        logic q_err;
        logic q_start;
        logic q_mul;
        logic q_acc;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] kind;
        logic       id_ok;
        logic       bnd_ok;
        logic       bnd_last;
        logic       q_defined;
        logic       clr_last;
        logic       walk_last;
        logic       q_last;
    } dp_status_t;

    // Flat address of one dimension entry of an array
    function automatic logic [BND_AW-1:0] row_addr(logic [ARR_W-1:0] id,
                                                   logic [POS_W-1:0] pos);
        return BND_AW'(32'(id) * MAX_DIMS + 32'(pos));
    endfunction

endpackage

[design/mdag_datapath.sv]
// ----------------------------------------------------------------------------
// mdag_datapath: descriptor tables, bound/stride memories and arithmetic
// Holds the item register, the descriptor and per-dimension memories, the
// shared 32x32 multiplier, the stride walk registers, the query accumulator
// and the result register. Acts only on controller commands.
// ----------------------------------------------------------------------------
module mdag_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mdag_pkg::in_item_t   item,
    input  mdag_pkg::dp_cmd_t    ctl,
    output mdag_pkg::dp_status_t stat,
    output mdag_pkg::out_item_t  result
);
    import mdag_pkg::*;

    // Item register
    in_item_t item_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            item_reg <= item;
        end
    end

    logic             id_ok;
    logic [ARR_W-1:0] id;
    assign id_ok = 32'(item_reg.array_id) < MAX_ARRAYS;
    assign id    = ARR_W'(item_reg.array_id);

    // Descriptor valid bits
    logic [MAX_ARRAYS-1:0] desc_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= '0;
        end
        else if (ctl.hdr_write)
        begin
            desc_valid_reg[id] <= 1'b1;
        end
    end

    // Descriptor memories, registered read at the item's id
    logic [DIM_W-1:0] desc_dims_mem [MAX_ARRAYS];
    logic [31:0]      desc_elem_mem [MAX_ARRAYS];
    logic [31:0]      desc_base_mem [MAX_ARRAYS];
    logic [31:0]      desc_off_mem  [MAX_ARRAYS];

    logic [DIM_W-1:0] dims_rd;
    logic [31:0]      elem_rd;
    logic [31:0]      base_rd;
    logic [31:0]      off_rd;
    logic [DIM_W-1:0] hdr_dims;
    logic [31:0]      off_acc_reg;

    // Clamp the header's dimension count to 1..MAX_DIMS
    always_comb
    begin
        priority if (item_reg.dim_count == 5'd0)
        begin
            hdr_dims = DIM_W'(1);
        end
        else if (32'(item_reg.dim_count) > MAX_DIMS)
        begin
            hdr_dims = DIM_W'(MAX_DIMS);
        end
        else
        begin
            hdr_dims = DIM_W'(item_reg.dim_count);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.hdr_write)
        begin
            desc_dims_mem[id] <= hdr_dims;
            desc_elem_mem[id] <= {1'b0, item_reg.element_size};
            desc_base_mem[id] <= item_reg.base_address;
        end
        if (ctl.hdr_write || ctl.off_write)
        begin
            desc_off_mem[id] <= ctl.hdr_write ? item_reg.base_address : off_acc_reg;
        end
        dims_rd <= desc_dims_mem[id];
        elem_rd <= desc_elem_mem[id];
        base_rd <= desc_base_mem[id];
        off_rd  <= desc_off_mem[id];
    end

    // Walk, sweep and query position registers
    logic [POS_W-1:0] k_reg, k_next;
    logic [POS_W-1:0] clr_cnt_reg;
    logic [POS_W-1:0] qpos_reg, qpos_next;
    logic [31:0]      qsum_reg, qsum_next;
    logic [31:0]      stride_cur_reg;
    logic [31:0]      ext_reg;
    logic [31:0]      prod_reg;
    logic [POS_W-1:0] dn_pos;

    assign dn_pos = POS_W'(item_reg.dim_number - 5'd1);

    // Bound and stride memories
    logic [31:0] bnd_low_mem  [BND_DEPTH];
    logic [31:0] bnd_high_mem [BND_DEPTH];
    logic [31:0] stride_mem   [BND_DEPTH];

    logic [31:0]       low_rd;
    logic [31:0]       high_rd;
    logic [31:0]       stride_rd;
    logic [BND_AW-1:0] bnd_waddr;
    logic [BND_AW-1:0] str_waddr;

    assign bnd_waddr = ctl.clr_write ? row_addr(id, clr_cnt_reg) : row_addr(id, dn_pos);
    assign str_waddr = ctl.clr_write ? row_addr(id, clr_cnt_reg) : row_addr(id, k_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.bnd_write || ctl.clr_write)
        begin
            bnd_low_mem[bnd_waddr]  <= ctl.clr_write ? 32'd0 : item_reg.lower_bound;
            bnd_high_mem[bnd_waddr] <= ctl.clr_write ? 32'd0 : item_reg.upper_bound;
        end
        if (ctl.stride_write || ctl.clr_write)
        begin
            stride_mem[str_waddr] <= ctl.clr_write ? 32'd0 : stride_cur_reg;
        end
        low_rd    <= bnd_low_mem[row_addr(id, k_reg)];
        high_rd   <= bnd_high_mem[row_addr(id, k_reg)];
        stride_rd <= stride_mem[row_addr(id, qpos_reg)];
    end

    // Shared multiplier, low 32 bits of the product
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_p;

    always_comb
    begin
        mul_a = stride_cur_reg;
        mul_b = low_rd;
        if (ctl.walk_mul_ext)
        begin
            mul_b = ext_reg;
        end
        if (ctl.q_mul)
        begin
            mul_a = item_reg.index_value;
            mul_b = stride_rd;
        end
    end

    assign mul_p = mul_a * mul_b;

    // Stride walk registers
    assign k_next = ctl.walk_start ? dn_pos : k_reg - POS_W'(1);

    always_ff @(posedge clk)
    begin
        if (ctl.walk_mul_low || ctl.walk_mul_ext || ctl.q_mul)
        begin
            prod_reg <= mul_p;
        end
        if (ctl.walk_mul_low)
        begin
            ext_reg <= high_rd - low_rd + 32'd1;
        end
        if (ctl.walk_start || ctl.walk_next)
        begin
            k_reg <= k_next;
        end
        if (ctl.walk_start)
        begin
            stride_cur_reg <= elem_rd;
        end
        else if (ctl.walk_next)
        begin
            stride_cur_reg <= prod_reg;
        end
        if (ctl.walk_start)
        begin
            off_acc_reg <= base_rd;
        end
        else if (ctl.walk_mul_ext)
        begin
            off_acc_reg <= off_acc_reg - prod_reg;
        end
    end

    // Row clear counter for header items
    always_ff @(posedge clk)
    begin
        if (ctl.hdr_write)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctl.clr_write)
        begin
            clr_cnt_reg <= clr_cnt_reg + POS_W'(1);
        end
    end

    // Query accumulator
    logic [POS_W-1:0] pos_eff;
    logic [31:0]      sum_new;
    logic             q_last;
    logic [31:0]      res_addr_reg;
    logic             res_err_reg;

    assign pos_eff = (32'(qpos_reg) >= 32'(dims_rd)) ? '0 : qpos_reg;
    assign sum_new = qsum_reg + prod_reg;
    assign q_last  = (32'(qpos_reg) + 32'd1) >= 32'(dims_rd);

    always_comb
    begin
        qpos_next = qpos_reg;
        qsum_next = qsum_reg;
        priority if (ctl.q_clear || ctl.q_err)
        begin
            qpos_next = '0;
            qsum_next = '0;
        end
        else if (ctl.q_start)
        begin
            qpos_next = pos_eff;
            qsum_next = (pos_eff == '0) ? off_rd : qsum_reg;
        end
        else if (ctl.q_acc)
        begin
            qpos_next = q_last ? '0 : qpos_reg + POS_W'(1);
            qsum_next = q_last ? 32'd0 : sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qpos_reg <= '0;
            qsum_reg <= '0;
        end
        else
        begin
            qpos_reg <= qpos_next;
            qsum_reg <= qsum_next;
        end
    end

    // Pending result and output register
    always_ff @(posedge clk)
    begin
        if (ctl.q_err)
        begin
            res_addr_reg <= 32'd0;
            res_err_reg  <= STATUS_UNDEF;
        end
        else if (ctl.q_acc)
        begin
            res_addr_reg <= sum_new;
            res_err_reg  <= STATUS_OK;
        end
        if (ctl.out_load)
        begin
            result.result_array <= item_reg.array_id;
            result.address      <= res_addr_reg;
            result.status       <= res_err_reg;
        end
    end

    // Status to the controller
    assign stat.kind      = item_reg.kind;
    assign stat.id_ok     = id_ok;
    assign stat.q_defined = id_ok && desc_valid_reg[id];
    assign stat.bnd_ok    = id_ok && desc_valid_reg[id] && (item_reg.dim_number != 5'd0)
                            && (32'(item_reg.dim_number) <= 32'(dims_rd));
    assign stat.bnd_last  = 32'(item_reg.dim_number) == 32'(dims_rd);
    assign stat.clr_last  = 32'(clr_cnt_reg) == (MAX_DIMS - 1);
    assign stat.walk_last = k_reg == '0;
    assign stat.q_last    = q_last;

endmodule

[design/mdag_controller.sv]
// ----------------------------------------------------------------------------
// mdag_controller: sequencing state machine of the address generator
// Accepts one item at a time, steps the datapath through descriptor lookup,
// row clear, stride walk or query accumulate, and owns the result valid.
// ----------------------------------------------------------------------------
module mdag_controller
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    output logic                 result_valid,
    input  logic                 result_ready,
    input  mdag_pkg::dp_status_t stat,
    output mdag_pkg::dp_cmd_t    ctl
);
    import mdag_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DESC   = 12'b0000_0000_0010,
        S_DECIDE = 12'b0000_0000_0100,
        S_CLEAR  = 12'b0000_0000_1000,
        S_W_RD   = 12'b0000_0001_0000,
        S_W_ML   = 12'b0000_0010_0000,
        S_W_ME   = 12'b0000_0100_0000,
        S_W_NX   = 12'b0000_1000_0000,
        S_Q_RD   = 12'b0001_0000_0000,
        S_Q_ML   = 12'b0010_0000_0000,
        S_Q_AC   = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_DESC;
                end
            end
            S_DESC:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
                unique case (stat.kind)
                    KIND_HEADER:
                    begin
                        ctl.q_clear = 1'b1;
                        if (stat.id_ok)
                        begin
                            ctl.hdr_write = 1'b1;
                            state_next    = S_CLEAR;
                        end
                    end
                    KIND_BOUNDS:
                    begin
                        ctl.q_clear = 1'b1;
                        if (stat.bnd_ok)
                        begin
                            ctl.bnd_write = 1'b1;
                            if (stat.bnd_last)
                            begin
                                ctl.walk_start = 1'b1;
                                state_next     = S_W_RD;
                            end
                        end
                    end
                    KIND_INDEX:
                    begin
                        if (stat.q_defined)
                        begin
                            ctl.q_start = 1'b1;
                            state_next  = S_Q_RD;
                        end
                        else
                        begin
                            ctl.q_err  = 1'b1;
                            state_next = S_OUT;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_CLEAR:
            begin
                ctl.clr_write = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_W_RD:
            begin
                ctl.stride_write = 1'b1;
                state_next       = S_W_ML;
            end
            S_W_ML:
            begin
                ctl.walk_mul_low = 1'b1;
                state_next       = S_W_ME;
            end
            S_W_ME:
            begin
                ctl.walk_mul_ext = 1'b1;
                state_next       = S_W_NX;
            end
            S_W_NX:
            begin
                if (stat.walk_last)
                begin
                    ctl.off_write = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    ctl.walk_next = 1'b1;
                    state_next    = S_W_RD;
                end
            end
            S_Q_RD:
            begin
                state_next = S_Q_ML;
            end
            S_Q_ML:
            begin
                ctl.q_mul  = 1'b1;
                state_next = S_Q_AC;
            end
            S_Q_AC:
            begin
                ctl.q_acc  = 1'b1;
                state_next = stat.q_last ? S_OUT : S_IDLE;
            end
            S_OUT:
            begin
                // wait for a free output slot
                if (!out_valid_reg || result_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid
    always_comb
    begin
        priority if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

[design/multidim_array_address_generator_unit.sv]
// ----------------------------------------------------------------------------
// multidim_array_address_generator_unit: row-major array address generator
// Keeps array descriptors, builds row-major strides and offsets, and turns
// streams of per-dimension indices into addresses.
// ----------------------------------------------------------------------------
// One item is in work at a time; item_ready is high again after it is done.
// A header beat zeroes its array's bounds and strides one dimension a cycle;
// a bounds beat for the last dimension adds a stride walk over all dimensions
// on the shared 32x32 multiplier; a query index beat passes descriptor read,
// stride read, multiply and accumulate, and an output step when it finishes
// the address; an index beat for an undefined array reports the error at
// once. A beat that produces a result also waits while the output register
// still holds an unaccepted beat.
// A finished result sits in an output register while the next beat is taken.
// No clearing pass follows reset.
module multidim_array_address_generator_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  mdag_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output mdag_pkg::out_item_t result
);
    import mdag_pkg::*;

    dp_cmd_t    ctl;
    dp_status_t stat;

    // Sequencer
    mdag_controller u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .ctl          (ctl)
    );

    // Tables and arithmetic
    mdag_datapath u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .ctl    (ctl),
        .stat   (stat),
        .result (result)
    );

endmodule
